[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the search block's controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/core/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants, payload types and controller/datapath link types for the
// sorted table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int KEY_WIDTH   = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int NUM_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths fixed by the interface
   localparam int IDX_W       = 8;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 9;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Opcodes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPARE_SIGNED = CSR_INDEX_W'(1);

   typedef struct packed {
      logic              opcode;
      logic [IDX_W-1:0]  entry_index;
      logic [DATA_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] match_index;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] entry_count;
      logic               compare_signed;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load_entry;    // write the request key into the table
      logic begin_search;  // capture key, reset search window
      logic read_cur;      // read the probe of the current window
      logic step;          // narrow the window and read its probe
      logic finish;        // capture the result
      logic use_hit;       // result comes from the last compare
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic n_zero;     // window is empty
      logic hit;        // probed entry equals the key
      logic last;       // probed entry was the only one left
      logic next_zero;  // narrowed window would be empty
   } dp_stat_type;

endpackage

`default_nettype wire

[rtl/core/stbs_dpath.sv]
// ----------------------------------------------------------------------------
// stbs_dpath
// Key table, search window registers, key compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_dpath (
   input  wire                   clock,
   input  stbs_pkg::req_type     req_data,
   input  stbs_pkg::cfg_type     cfg,
   input  stbs_pkg::dp_cmd_type  cmd,
   output stbs_pkg::dp_stat_type stat,
   output stbs_pkg::rsp_type     rsp_data
);
   import stbs_pkg::*;

   // Probe position of a window: middle, or just below it for even sizes
   function automatic logic [NUM_W-1:0] probe_of(input logic [NUM_W-1:0] lo,
                                                 input logic [NUM_W-1:0] n);
      logic [NUM_W-1:0] half;
      half = n >> 1;
      return n[0] ? (lo + half) : (lo + half - NUM_W'(1));
   endfunction

   logic [KEY_WIDTH-1:0] key_table [TABLE_DEPTH];

   logic [KEY_WIDTH-1:0] key_ff;
   logic [NUM_W-1:0]     lo_ff;
   logic [NUM_W-1:0]     n_ff;
   logic [ADDR_W-1:0]    probe_ff;
   logic [KEY_WIDTH-1:0] rd_data_ff;
   rsp_type              rsp_ff;

   logic [NUM_W-1:0]         lo_in;
   logic [NUM_W-1:0]         n_in;
   logic [NUM_W-1:0]         half;
   logic [NUM_W-1:0]         mid_cur;
   logic [NUM_W-1:0]         rd_pos;
   logic [ADDR_W-1:0]        rd_addr;
   logic [NUM_W-1:0]         n_start;
   logic [COUNT_W+NUM_W-1:0] count_wide;
   logic [IDX_W+ADDR_W-1:0]  wr_wide;
   logic [IDX_W+ADDR_W-1:0]  probe_wide;
   logic [KEY_WIDTH-1:0]     sign_flip;
   logic [KEY_WIDTH-1:0]     cmp_a;
   logic [KEY_WIDTH-1:0]     cmp_b;
   logic                     hit;
   logic                     less;

   // Saturate the configured count to the table depth
   assign count_wide = {{NUM_W{1'b0}}, cfg.entry_count};
   assign n_start    = (count_wide > (COUNT_W+NUM_W)'(TABLE_DEPTH)) ?
                       NUM_W'(TABLE_DEPTH) : count_wide[NUM_W-1:0];

   // Compare key against probed entry; bias sign bit for signed mode
   assign sign_flip = cfg.compare_signed ? {1'b1, {(KEY_WIDTH-1){1'b0}}} : '0;
   assign cmp_a     = key_ff ^ sign_flip;
   assign cmp_b     = rd_data_ff ^ sign_flip;
   assign hit       = (cmp_a == cmp_b);
   assign less      = (cmp_a < cmp_b);

   // Narrow the window around the probe
   assign half    = n_ff >> 1;
   assign mid_cur = probe_of(lo_ff, n_ff);

   always_comb begin
      if (less) begin
         lo_in = lo_ff;
         n_in  = n_ff[0] ? half : (half - NUM_W'(1));
      end else begin
         lo_in = mid_cur + NUM_W'(1);
         n_in  = half;
      end
   end

   assign rd_pos  = cmd.step ? probe_of(lo_in, n_in) : mid_cur;
   assign rd_addr = rd_pos[ADDR_W-1:0];

   assign stat.n_zero    = (n_ff == '0);
   assign stat.hit       = hit;
   assign stat.last      = (half == '0);
   assign stat.next_zero = (n_in == '0);

   // Table write port and registered read port
   assign wr_wide = {{ADDR_W{1'b0}}, req_data.entry_index};

   always_ff @(posedge clock) begin
      if (cmd.load_entry && (wr_wide < (IDX_W+ADDR_W)'(TABLE_DEPTH))) begin
         key_table[wr_wide[ADDR_W-1:0]] <= req_data.data_value[KEY_WIDTH-1:0];
      end
      if (cmd.read_cur || cmd.step) begin
         rd_data_ff <= key_table[rd_addr];
      end
   end

   // Search window and probe position
   always_ff @(posedge clock) begin
      if (cmd.begin_search) begin
         key_ff <= req_data.data_value[KEY_WIDTH-1:0];
         lo_ff  <= '0;
         n_ff   <= n_start;
      end else if (cmd.step) begin
         lo_ff <= lo_in;
         n_ff  <= n_in;
      end
      if (cmd.read_cur || cmd.step) begin
         probe_ff <= rd_addr;
      end
   end

   // Capture the result
   assign probe_wide = {{IDX_W{1'b0}}, probe_ff};

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.found       <= cmd.use_hit && hit;
         rsp_ff.match_index <= (cmd.use_hit && hit) ? probe_wide[IDX_W-1:0] : '0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/stbs_ctrl.sv]
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for load and search transactions: issues table reads, watches
// compare status and strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stbs_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire                   req_opcode,
   input  stbs_pkg::dp_stat_type stat,
   output stbs_pkg::dp_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_strobe
);
   import stbs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_opcode)
                  OP_LOAD: begin
                     cmd.load_entry = 1'b1;
                  end
                  OP_SEARCH: begin
                     cmd.begin_search = 1'b1;
                     state_in         = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (stat.n_zero) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.read_cur = 1'b1;
               state_in     = ST_CMP;
            end
         end
         ST_CMP: begin
            if (stat.hit || stat.last || stat.next_zero) begin
               cmd.finish  = 1'b1;
               cmd.use_hit = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;

   `ASSERT_IMPLY(a_rsp_while_idle, clock, reset, rsp_strobe, !busy)
   `ASSERT_NEXT(a_finish_strobes, clock, reset, cmd.finish, rsp_strobe)
   `ASSERT_IMPLY(a_cmp_after_read, clock, reset, state_ff == ST_CMP, $past(cmd.read_cur || cmd.step))
   `ASSERT_NEXT(a_search_goes_busy, clock, reset, start && !busy && req_opcode == OP_SEARCH, busy)

endmodule

`default_nettype wire

[rtl/core/sorted_table_binary_search.sv]
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a table of sorted keys, loaded one entry at a time.
// ----------------------------------------------------------------------------
// A load transaction gives no result. A search transaction keeps busy high
// while it probes the table (at most 9 probes for 256 entries, fewer on an
// early match or a short table); the result is strobed on rsp_strobe for
// one cycle right after busy drops, and a new transaction may start in that
// same cycle. Probes run one after another through the single registered
// read port of the key table.
// The receiver cannot stall: capture rsp_data whenever rsp_strobe is high.
// Table entries are not cleared by reset; load every entry below
// entry_count before searching. Write csr registers only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  stbs_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output stbs_pkg::rsp_type                 rsp_data,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [stbs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire [stbs_pkg::CSR_DATA_W-1:0]    csr_data
);
   import stbs_pkg::*;

   logic [COUNT_W-1:0] entry_count_ff;
   logic               compare_signed_ff;
   cfg_type            cfg;
   dp_cmd_type         cmd;
   dp_stat_type        stat;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff    <= '0;
         compare_signed_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENTRY_COUNT: begin
               entry_count_ff <= csr_data[COUNT_W-1:0];
            end
            CSR_COMPARE_SIGNED: begin
               compare_signed_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.entry_count    = entry_count_ff;
   assign cfg.compare_signed = compare_signed_ff;

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_data.opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   stbs_dpath u_dpath (
      .clock    (clock),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

[tb/sorted_table_binary_search_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb
// Self-checking bench for the sorted table binary search block. Load and
// search transactions are driven through the start/busy port. A scoreboard
// mirrors the key table and both registers, predicts every search answer and
// compares it with each strobed result. The run covers a short directed part
// (empty, tiny, saturated, signed and unsorted tables) and then sorted random
// tables, mostly small, with noise loads and sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search_tb;
   import stbs_pkg::*;

   localparam int SETTLE_CYCLES = 20;

   // Mirror of the block: key table, registers and the answers still due
   class lookup_scoreboard;
      logic [DATA_W-1:0]  key_mem [TABLE_DEPTH];
      logic [COUNT_W-1:0] entry_count;
      logic               compare_signed;
      rsp_type            expected_lookups [$];
      int                 errors;
      int                 answers;

      function new();
         entry_count    = '0;
         compare_signed = 1'b0;
         errors         = 0;
         answers        = 0;
         foreach (key_mem[i]) key_mem[i] = '0;
      endfunction

      task report(string what);
         errors++;
         $display("ERROR: %s", what);
      endtask

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] word);
         if (idx == CSR_ENTRY_COUNT) begin
            entry_count = word[COUNT_W-1:0];
         end else if (idx == CSR_COMPARE_SIGNED) begin
            compare_signed = word[0];
         end
      endfunction

      // Three-way compare; flip the sign bits for two's complement order
      function int key_order(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
         if (compare_signed) begin
            a[DATA_W-1] = ~a[DATA_W-1];
            b[DATA_W-1] = ~b[DATA_W-1];
         end
         if (a < b) return -1;
         if (a > b) return 1;
         return 0;
      endfunction

      // Apply a load, or walk the fixed probe order and queue the answer
      function void note_request(req_type r);
         int      lo, n, half, mid, c, at;
         logic    hit, done;
         rsp_type answer;
         if (r.opcode == OP_LOAD) begin
            key_mem[r.entry_index] = r.data_value;
         end else begin
            n    = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
            lo   = 0;
            hit  = 1'b0;
            at   = 0;
            done = (n == 0);
            while (!done) begin
               half = n / 2;
               if (half == 0) begin
                  // one entry left: compare it last
                  if (key_order(r.data_value, key_mem[lo]) == 0) begin
                     hit = 1'b1;
                     at  = lo;
                  end
                  done = 1'b1;
               end else begin
                  mid = lo + ((n % 2 == 1) ? half : half - 1);
                  c   = key_order(r.data_value, key_mem[mid]);
                  if (c == 0) begin
                     hit  = 1'b1;
                     at   = mid;
                     done = 1'b1;
                  end else if (c < 0) begin
                     n = (n % 2 == 1) ? half : half - 1;
                  end else begin
                     lo = mid + 1;
                     n  = half;
                  end
                  if (n == 0) done = 1'b1;
               end
            end
            answer.found       = hit;
            answer.match_index = hit ? IDX_W'(at) : '0;
            expected_lookups.push_back(answer);
         end
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         answers++;
         if (expected_lookups.size() == 0) begin
            report($sformatf("answer %0d arrived with no search outstanding", answers));
         end else begin
            want = expected_lookups.pop_front();
            if (got.found !== want.found)
               report($sformatf("answer %0d found: got %b, want %b",
                                answers, got.found, want.found));
            if (got.match_index !== want.match_index)
               report($sformatf("answer %0d match_index: got %0d, want %0d",
                                answers, got.match_index, want.match_index));
         end
      endtask

      task close_out();
         if (expected_lookups.size() != 0)
            report($sformatf("%0d searches never answered", expected_lookups.size()));
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   start      = 1'b0;
   logic                   busy;
   req_type                req_data   = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   lookup_scoreboard board;
   int               items_sent = 0;
   int               idle_pct   = 23;

   sorted_table_binary_search dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Capture every strobed answer; the receiver never stalls
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_result(rsp_data);
   end

   // Hold start until the block takes the transaction; start stays high after
   task automatic send_item(req_type item);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      board.note_request(item);
      items_sent++;
      // sender idles lightly, then heavily, then not at all
      idle_pct = (items_sent < 217) ? 23 : (items_sent < 434) ? 67 : 0;
   endtask

   task automatic load_entry(int idx, logic [DATA_W-1:0] value);
      req_type item;
      item.opcode      = OP_LOAD;
      item.entry_index = IDX_W'(idx);
      item.data_value  = value;
      send_item(item);
   endtask

   task automatic search_key(logic [DATA_W-1:0] value);
      req_type item;
      item.opcode      = OP_SEARCH;
      item.entry_index = IDX_W'($urandom_range(255));
      item.data_value  = value;
      send_item(item);
   endtask

   // Drop start and wait until every search is answered and the block is quiet
   task automatic settle();
      start <= 1'b0;
      while (board.expected_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back while idle
   task automatic configure(int unsigned count, bit signed_mode);
      settle();
      csr_valid <= 1'b1;
      csr_index <= CSR_ENTRY_COUNT;
      csr_data  <= CSR_DATA_W'(count);
      do @(posedge clock); while (!csr_ready);
      board.set_register(CSR_ENTRY_COUNT, CSR_DATA_W'(count));
      csr_index <= CSR_COMPARE_SIGNED;
      csr_data  <= CSR_DATA_W'(signed_mode);
      do @(posedge clock); while (!csr_ready);
      board.set_register(CSR_COMPARE_SIGNED, CSR_DATA_W'(signed_mode));
      csr_valid <= 1'b0;
   endtask

   // Mostly keys present in the table, then neighbors, extremes and noise
   function automatic logic [DATA_W-1:0] pick_key(int span);
      int                sel;
      logic [DATA_W-1:0] k;
      sel = $urandom_range(99);
      if (sel >= 95) begin
         case ($urandom_range(3))
            0:       k = 32'h0000_0000;
            1:       k = 32'hFFFF_FFFF;
            2:       k = 32'h8000_0000;
            default: k = 32'h7FFF_FFFF;
         endcase
      end else if (span == 0 || sel >= 85) begin
         k = $urandom();
      end else begin
         k = board.key_mem[$urandom_range(span - 1)];
         if (sel >= 65) k = $urandom_range(1) ? k + 1 : k - 1;
      end
      return k;
   endfunction

   // Configure, optionally reload a sorted prefix, then search with some noise loads
   task automatic run_phase(int unsigned count, bit signed_mode, bit reload, int searches);
      int          span, k;
      bit [31:0]   vals [$];
      bit [31:0]   base, flip;
      bit          clustered;
      span = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
      flip = signed_mode ? 32'h8000_0000 : 32'h0;
      configure(count, signed_mode);
      if (reload && span > 0) begin
         clustered = ($urandom_range(3) == 0);
         base      = $urandom();
         for (k = 0; k < span; k++)
            vals.push_back(clustered ? base + $urandom_range(2 * span) : $urandom());
         // sort in the compare order of this phase
         vals.sort();
         for (k = 0; k < span; k++) load_entry(k, vals[k] ^ flip);
      end
      for (k = 0; k < searches; k++) begin
         if (span > 0 && $urandom_range(99) < 8)
            load_entry($urandom_range(span - 1), $urandom());
         else
            search_key(pick_key(span));
      end
   endtask

   initial begin
      int unsigned count;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table: no probe at all
      search_key(32'h0000_0000);
      search_key(32'hFFFF_FFFF);
      load_entry(0, 32'h0000_0005);
      load_entry(1, 32'h8000_0000);
      load_entry(2, 32'hFFFF_FFFF);
      // single entry: only the last compare
      configure(1, 1'b0);
      search_key(32'h0000_0005);
      search_key(32'h0000_0004);
      // two entries: even window probes its lower middle
      configure(2, 1'b0);
      search_key(32'h8000_0000);
      search_key(32'h0000_0005);
      search_key(32'h0000_0006);
      configure(3, 1'b0);
      search_key(32'hFFFF_FFFF);
      search_key(32'h0000_0000);
      search_key(32'h8000_0000);
      // unsigned order read as signed: table is no longer sorted
      configure(3, 1'b1);
      search_key(32'hFFFF_FFFF);
      search_key(32'h0000_0005);
      // signed ascending table
      load_entry(0, 32'h8000_0000);
      load_entry(1, 32'hFFFF_FFFF);
      load_entry(2, 32'h7FFF_FFFF);
      search_key(32'h8000_0000);
      search_key(32'h7FFF_FFFF);
      search_key(32'hFFFF_FFFF);
      search_key(32'h0000_0000);

      // full table, then a saturated count and a count one short of full
      run_phase(256, 1'b0, 1'b1, 40);
      run_phase(511, 1'b0, 1'b0, 30);
      run_phase(255, 1'b0, 1'b0, 30);
      run_phase(256, 1'b1, 1'b0, 25);

      // mostly small sorted tables
      while (items_sent < 650) begin
         if ($urandom_range(9) == 0) count = $urandom_range(2);
         else count = $urandom_range(1, 24);
         run_phase(count, 1'($urandom_range(1)), 1'b1, int'($urandom_range(8, 20)));
      end

      settle();
      board.close_out();
      if (board.errors == 0) begin
         $display("sorted_table_binary_search: match");
      end else begin
         $display("sorted_table_binary_search: mismatch");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("sorted_table_binary_search: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
